>>> src/ptmi_pkg.sv
`default_nettype none
package ptmi_pkg;

   localparam int unsigned POOL_PAGES_DEFAULT      = 16;
   localparam int unsigned FIRST_FREE_PAGE_DEFAULT = 4;
   localparam int unsigned ENTRIES_PER_TABLE       = 512;
   localparam int unsigned IDX_W                   = 9;
   localparam int unsigned VP_W                    = 36;
   localparam int unsigned PP_W                    = 40;
   localparam int unsigned FLAGS_W                 = 64;
   localparam int unsigned ENTRY_W                 = 64;
   localparam int unsigned DIR_FLAG_W              = 6;

   localparam logic [ENTRY_W-1:0] KEEP_MASK   = 64'hFFF0_0000_0000_0FFF;
   localparam logic [ENTRY_W-1:0] PRESENT_BIT = 64'h1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_OUTSIDE   = 2'd2,
      ST_HALTED    = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;      // capture request fields
      logic       rd;        // read the entry of the current level
      logic       alloc;     // take a fresh page for a missing level
      logic       link;      // follow a present directory entry
      logic       fail;      // stop the walk with fail_code
      status_type fail_code;
      logic       clr_all;   // one step of the post-reset sweep
      logic       clr_page;  // one step of clearing a fresh page
      logic       wr_dir;    // write the directory entry and descend
      logic       wr_leaf;   // write the leaf entry
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic halted;
      logic present;
      logic rel_bad;
      logic pool_full;
      logic leaf;
      logic page_clr_last;
      logic mem_clr_last;
   } stat_type;

   function automatic logic [ENTRY_W-1:0] put_frame(input logic [ENTRY_W-1:0] entry,
                                                   input logic [PP_W-1:0] frame);
      put_frame = (entry & KEEP_MASK) | {12'b0, frame, 12'b0};
   endfunction

endpackage
`default_nettype wire

>>> src/ptmi_req_if.sv
`default_nettype none
interface ptmi_req_if;
   logic                          valid;
   logic                          ready;
   logic [ptmi_pkg::VP_W-1:0]     virt_page;
   logic [ptmi_pkg::PP_W-1:0]     phys_page;
   logic [ptmi_pkg::FLAGS_W-1:0]  flags;
   modport source (output valid, virt_page, phys_page, flags, input ready);
   modport sink   (input valid, virt_page, phys_page, flags, output ready);
endinterface
`default_nettype wire

>>> src/ptmi_rsp_if.sv
`default_nettype none
interface ptmi_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [1:0]                  pages_taken;
   logic [ptmi_pkg::VP_W-1:0]   flush_page;
   modport source (output valid, status, pages_taken, flush_page, input ready);
   modport sink   (input valid, status, pages_taken, flush_page, output ready);
endinterface
`default_nettype wire

>>> src/ptmi_ram.sv
`default_nettype none
module ptmi_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

>>> src/ptmi_datapath.sv
`default_nettype none
module ptmi_datapath #(
   parameter int unsigned POOL_PAGES      = ptmi_pkg::POOL_PAGES_DEFAULT,
   parameter int unsigned FIRST_FREE_PAGE = ptmi_pkg::FIRST_FREE_PAGE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptmi_pkg::cmd_type             cmd,
   output ptmi_pkg::stat_type                 stat,
   input  wire logic [ptmi_pkg::VP_W-1:0]     virt_page,
   input  wire logic [ptmi_pkg::PP_W-1:0]     phys_page,
   input  wire logic [ptmi_pkg::FLAGS_W-1:0]  flags,
   input  wire logic                          csr_wr_en,
   input  wire logic [ptmi_pkg::PP_W-1:0]     csr_wr_data,
   output logic      [1:0]                    status,
   output logic      [1:0]                    pages_taken,
   output logic      [ptmi_pkg::VP_W-1:0]     flush_page
);
   import ptmi_pkg::*;

   localparam int unsigned PW    = $clog2(POOL_PAGES);
   localparam int unsigned AW    = PW + IDX_W;
   localparam int unsigned DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
   localparam int unsigned NFMAX = (POOL_PAGES > FIRST_FREE_PAGE) ? POOL_PAGES
                                                                  : FIRST_FREE_PAGE;
   localparam int unsigned NFW   = $clog2(NFMAX + 1);

   logic [PP_W-1:0]    base_ff, base_in;
   logic [VP_W-1:0]    vp_ff, vp_in;
   logic [PP_W-1:0]    pp_ff, pp_in;
   logic [FLAGS_W-1:0] fl_ff, fl_in;
   logic [1:0]         level_ff, level_in;
   logic [PW-1:0]      table_ff, table_in;
   logic [PW-1:0]      child_ff, child_in;
   logic [ENTRY_W-1:0] pend_ff, pend_in;
   logic [NFW-1:0]     nfp_ff, nfp_in;
   logic [1:0]         taken_ff, taken_in;
   logic               halted_ff, halted_in;
   status_type         status_ff, status_in;
   logic [AW-1:0]      clr_ff, clr_in;

   logic [IDX_W-1:0]   idx;
   logic [AW-1:0]      slot;
   logic [ENTRY_W-1:0] rdata;
   logic [ENTRY_W-1:0] dflags;
   logic [PP_W-1:0]    rel;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   always_comb begin
      unique case (level_ff)
         2'd3:    idx = vp_ff[35:27];
         2'd2:    idx = vp_ff[26:18];
         2'd1:    idx = vp_ff[17:9];
         default: idx = vp_ff[8:0];
      endcase
   end

   assign slot   = {table_ff, idx};
   assign dflags = {{(ENTRY_W-DIR_FLAG_W){1'b0}}, fl_ff[DIR_FLAG_W-1:0]};
   assign rel    = rdata[51:12] - base_ff;

   assign stat.halted        = halted_ff;
   assign stat.present       = rdata[0];
   assign stat.rel_bad       = rel >= PP_W'(POOL_PAGES);
   assign stat.pool_full     = nfp_ff >= NFW'(POOL_PAGES);
   assign stat.leaf          = level_ff == 2'd0;
   assign stat.page_clr_last = &clr_ff[IDX_W-1:0];
   assign stat.mem_clr_last  = clr_ff == AW'(DEPTH - 1);

   always_comb begin
      mem_we    = cmd.clr_all | cmd.clr_page | cmd.wr_dir | cmd.wr_leaf;
      mem_waddr = slot;
      mem_wdata = pend_ff;
      if (cmd.clr_all) begin
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.clr_page) begin
         mem_waddr = {child_ff, clr_ff[IDX_W-1:0]};
         mem_wdata = '0;
      end else if (cmd.wr_leaf) begin
         mem_wdata = put_frame(rdata | PRESENT_BIT | fl_ff, pp_ff);
      end
   end

   ptmi_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (cmd.rd),
      .raddr (slot),
      .rdata (rdata)
   );

   always_comb begin
      base_in   = csr_wr_en ? csr_wr_data : base_ff;
      vp_in     = vp_ff;
      pp_in     = pp_ff;
      fl_in     = fl_ff;
      level_in  = level_ff;
      table_in  = table_ff;
      child_in  = child_ff;
      pend_in   = pend_ff;
      nfp_in    = nfp_ff;
      taken_in  = taken_ff;
      halted_in = halted_ff;
      status_in = status_ff;
      clr_in    = clr_ff;
      if (cmd.load) begin
         vp_in     = virt_page;
         pp_in     = phys_page;
         fl_in     = flags;
         level_in  = 2'd3;
         table_in  = '0;
         taken_in  = '0;
         status_in = halted_ff ? ST_HALTED : ST_OK;
      end
      if (cmd.alloc) begin
         child_in = nfp_ff[PW-1:0];
         pend_in  = put_frame(rdata | PRESENT_BIT, base_ff + PP_W'(nfp_ff)) | dflags;
         nfp_in   = nfp_ff + NFW'(1);
         taken_in = taken_ff + 2'd1;
         clr_in   = '0;
      end
      if (cmd.link) begin
         child_in = rel[PW-1:0];
         pend_in  = rdata | dflags;
      end
      if (cmd.fail) begin
         status_in = cmd.fail_code;
         halted_in = 1'b1;
      end
      if (cmd.clr_all || cmd.clr_page) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.wr_dir) begin
         table_in = child_ff;
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         nfp_ff    <= NFW'(FIRST_FREE_PAGE);
         halted_ff <= 1'b0;
         clr_ff    <= '0;
         status_ff <= ST_OK;
         taken_ff  <= '0;
         level_ff  <= 2'd3;
         table_ff  <= '0;
      end else begin
         base_ff   <= base_in;
         nfp_ff    <= nfp_in;
         halted_ff <= halted_in;
         clr_ff    <= clr_in;
         status_ff <= status_in;
         taken_ff  <= taken_in;
         level_ff  <= level_in;
         table_ff  <= table_in;
      end
      vp_ff    <= vp_in;
      pp_ff    <= pp_in;
      fl_ff    <= fl_in;
      child_ff <= child_in;
      pend_ff  <= pend_in;
   end

   assign status      = status_ff;
   assign pages_taken = taken_ff;
   assign flush_page  = (status_ff == ST_OK) ? vp_ff : '0;
endmodule
`default_nettype wire

>>> src/ptmi_ctrl.sv
`default_nettype none
module ptmi_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ptmi_pkg::stat_type stat,
   output ptmi_pkg::cmd_type       cmd,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready
);
   import ptmi_pkg::*;

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_ZERO  = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_all = 1'b1;
            if (stat.mem_clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.halted ? S_RESP : S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.leaf) begin
               cmd.wr_leaf = 1'b1;
               state_in    = S_RESP;
            end else if (stat.present) begin
               if (stat.rel_bad) begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_OUTSIDE;
                  state_in      = S_RESP;
               end else begin
                  cmd.link = 1'b1;
                  state_in = S_WRITE;
               end
            end else if (stat.pool_full) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_EXHAUSTED;
               state_in      = S_RESP;
            end else begin
               cmd.alloc = 1'b1;
               state_in  = S_ZERO;
            end
         end
         S_ZERO: begin
            cmd.clr_page = 1'b1;
            if (stat.page_clr_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.wr_dir = 1'b1;
            state_in   = S_READ;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

>>> src/page_table_map_inserter.sv
// Four-level page table inserter over a fixed pool of table pages.
// The req_ch channel takes one mapping per transfer: a virtual page, a
// physical frame and a flag word. The rsp_ch channel returns one result per
// mapping: a status, the number of table pages taken and the page to flush.
// The csr port writes the physical page number of the pool base; write it
// only while the block is idle.
// After reset the block sweeps the whole table store to zero, one entry per
// cycle, over all POOL_PAGES * 512 entries; req_ch.ready stays low
// meanwhile. Afterwards the block works on one mapping at a time.
// Each directory level takes a read, an evaluate and a write step, plus a
// clearing pass over all 512 entries of a new table page when it needs
// one, and the leaf takes a read and an evaluate step that writes it.
// With a step to accept and one for the result transfer, a mapping that
// needs three new pages holds the block longest. The single port pair of
// the table memory and the page clearing loop set how long it is held.
// A halted block answers with the halted status without walking the table.
// The result waits in its register while rsp_ch.ready is low, and no new
// request is taken until that result transfer completes.
`default_nettype none
module page_table_map_inserter #(
   parameter int unsigned POOL_PAGES      = ptmi_pkg::POOL_PAGES_DEFAULT,
   parameter int unsigned FIRST_FREE_PAGE = ptmi_pkg::FIRST_FREE_PAGE_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   ptmi_req_if.sink                        req_ch,
   ptmi_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [ptmi_pkg::PP_W-1:0]  csr_wr_data
);
   import ptmi_pkg::*;

   // Command and status between the sequencer and the walk datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes and sequences the walk.
   ptmi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .cmd       (cmd),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

   // The datapath holds the table store, allocator and result registers.
   ptmi_datapath #(
      .POOL_PAGES      (POOL_PAGES),
      .FIRST_FREE_PAGE (FIRST_FREE_PAGE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .virt_page   (req_ch.virt_page),
      .phys_page   (req_ch.phys_page),
      .flags       (req_ch.flags),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (rsp_ch.status),
      .pages_taken (rsp_ch.pages_taken),
      .flush_page  (rsp_ch.flush_page)
   );
endmodule
`default_nettype wire

>>> src/ptmi_checker.sv
`default_nettype none
module ptmi_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [1:0]                 rsp_status,
   input wire logic [1:0]                 rsp_pages_taken,
   input wire logic [ptmi_pkg::VP_W-1:0]  rsp_flush_page
);
   import ptmi_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_pages_taken) && $stable(rsp_flush_page))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   a_fail_no_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_flush_page == '0)
      else $error("flush page given for a failed mapping");

   a_halted_no_pages: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_HALTED |-> rsp_pages_taken == 2'd0)
      else $error("halted result reports taken pages");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("handshake active right after reset");
endmodule

bind page_table_map_inserter ptmi_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_pages_taken (rsp_ch.pages_taken),
   .rsp_flush_page  (rsp_ch.flush_page)
);
`default_nettype wire
